// ===== rtl/ddur_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and helper functions for the distance display unit rounder.
// No dependencies; compile first.
package ddur_pkg;

  localparam int DIST_W     = 32;
  localparam int WHOLE_W    = 23;
  localparam int TENTHS_W   = 4;
  localparam int UNIT_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_SYSTEM  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_ENABLE = 1'd1;

  // unit_system codes (the unused code behaves as metric)
  localparam logic [1:0] US_METRIC = 2'd0;
  localparam logic [1:0] US_YARDS  = 2'd1;
  localparam logic [1:0] US_FEET   = 2'd2;

  // unit_code values
  localparam logic [UNIT_W-1:0] UNIT_M  = 3'd0;
  localparam logic [UNIT_W-1:0] UNIT_KM = 3'd1;
  localparam logic [UNIT_W-1:0] UNIT_YD = 3'd2;
  localparam logic [UNIT_W-1:0] UNIT_FT = 3'd3;
  localparam logic [UNIT_W-1:0] UNIT_MI = 3'd4;

  // display category picked from the distance and the unit system
  typedef logic [2:0] cat_t;
  localparam cat_t CAT_KM_WHOLE  = 3'd0;
  localparam cat_t CAT_KM_TENTHS = 3'd1;
  localparam cat_t CAT_METERS    = 3'd2;
  localparam cat_t CAT_MI_WHOLE  = 3'd3;
  localparam cat_t CAT_MI_TENTHS = 3'd4;
  localparam cat_t CAT_YARDS     = 3'd5;
  localparam cat_t CAT_FEET      = 3'd6;

  // rounding base codes
  typedef logic [2:0] rbase_t;
  localparam rbase_t RB_NONE = 3'd0;
  localparam rbase_t RB_5    = 3'd1;
  localparam rbase_t RB_10   = 3'd2;
  localparam rbase_t RB_25   = 3'd3;
  localparam rbase_t RB_50   = 3'd4;

  // category thresholds on the distance in meters
  localparam logic [DIST_W-1:0] KM_WHOLE_ABOVE  = 32'd10000;
  localparam logic [DIST_W-1:0] KM_TENTHS_ABOVE = 32'd1000;
  localparam logic [DIST_W-1:0] MI_WHOLE_MIN    = 32'd16094; // more than 10 mi
  localparam logic [DIST_W-1:0] MI_YD_MIN       = 32'd805;   // more than 0.5 mi
  localparam logic [DIST_W-1:0] MI_FT_MIN       = 32'd242;   // more than 0.15 mi

  // reciprocals floor(2^s / divisor); the quotient estimate is short by at most one
  localparam logic [23:0] R_KM   = 24'd8589934; // /125,    s = 30
  localparam logic [8:0]  R_HM   = 9'd327;      // /100,    s = 15
  localparam logic [21:0] R_MIW  = 22'd2732819; // /12573,  s = 35
  localparam logic [7:0]  R_MIT  = 8'd166;      // /201168, s = 25
  localparam logic [10:0] R_YD   = 11'd1834;    // /1143,   s = 21
  localparam logic [10:0] R_FT   = 11'd1376;    // /381,    s = 19

  // exact ceil(2^20 / base) multipliers for values below 4096
  function automatic logic [17:0] rb_magic(input rbase_t rb);
    case (rb)
      RB_5:    rb_magic = 18'd209716;
      RB_10:   rb_magic = 18'd104858;
      RB_25:   rb_magic = 18'd41944;
      RB_50:   rb_magic = 18'd20972;
      default: rb_magic = 18'd0;
    endcase
  endfunction

  function automatic logic [4:0] rb_half(input rbase_t rb);
    case (rb)
      RB_5:    rb_half = 5'd2;
      RB_10:   rb_half = 5'd5;
      RB_25:   rb_half = 5'd12;
      RB_50:   rb_half = 5'd25;
      default: rb_half = 5'd0;
    endcase
  endfunction

  function automatic logic [5:0] rb_base(input rbase_t rb);
    case (rb)
      RB_5:    rb_base = 6'd5;
      RB_10:   rb_base = 6'd10;
      RB_25:   rb_base = 6'd25;
      RB_50:   rb_base = 6'd50;
      default: rb_base = 6'd1;
    endcase
  endfunction

endpackage

// ===== rtl/ddur_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the distance display unit rounder.
// Depends on ddur_pkg for field widths.
interface ddur_in_if;
  logic                         valid;
  logic                         ready;
  logic [ddur_pkg::DIST_W-1:0]  distance_m;
  logic                         is_altitude;

  modport source(output valid, distance_m, is_altitude, input ready);
  modport sink(input valid, distance_m, is_altitude, output ready);
endinterface

interface ddur_out_if;
  logic                           valid;
  logic                           ready;
  logic [ddur_pkg::WHOLE_W-1:0]   whole_value;
  logic [ddur_pkg::TENTHS_W-1:0]  tenths_digit;
  logic                           has_tenths;
  logic [ddur_pkg::UNIT_W-1:0]    unit_code;

  modport source(output valid, whole_value, tenths_digit, has_tenths, unit_code, input ready);
  modport sink(input valid, whole_value, tenths_digit, has_tenths, unit_code, output ready);
endinterface

// ===== rtl/distance_display_unit_rounder.sv =====
`timescale 1ns / 1ps
// Top level of the distance display unit rounder: five-register pipeline.
// Depends on ddur_pkg and the channel interfaces in ddur_if.sv.

// Converts a distance in whole meters into a display value (whole part, optional
// tenths digit, unit code) in metric, yards or feet mode. One beat is accepted
// every cycle while the pipeline is not stalled; each beat passes in order through an
// input register of scaled numerators, a reciprocal-multiply stage, a correction
// stage, a rounding stage and the output register. Each stage has its own valid
// bit, so a stalled output only holds the beats behind it while bubbles are still
// squeezed out. Write the configuration only while no beat is in flight.
module distance_display_unit_rounder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ddur_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ddur_pkg::CFG_DATA_W-1:0]   cfg_data,
  ddur_in_if.sink                           in_ch,
  ddur_out_if.source                        out_ch
);

  typedef struct packed {
    ddur_pkg::cat_t cat;
    logic [9:0]     m;
    logic [29:0]    n1;   // (d + 500) / 8
    logic [14:0]    n2;   // d + 50
    logic [34:0]    n3;   // (125 d + 100584) / 16
    logic [24:0]    n4;   // 1250 d + 100584
    logic [20:0]    n5;   // 1250 d
    logic [18:0]    n6;   // 1250 d
  } st1_t;

  typedef struct packed {
    ddur_pkg::cat_t cat;
    logic [9:0]     m;
    logic [29:0]    n1;
    logic [14:0]    n2;
    logic [34:0]    n3;
    logic [24:0]    n4;
    logic [20:0]    n5;
    logic [18:0]    n6;
    logic [53:0]    p1;
    logic [23:0]    p2;
    logic [39:0]    p3h;
    logic [38:0]    p3l;
    logic [32:0]    p4;
    logic [31:0]    p5;
    logic [29:0]    p6;
  } st2_t;

  typedef struct packed {
    ddur_pkg::cat_t cat;
    logic [9:0]     m;
    logic [22:0]    q1;
    logic [7:0]     q2;
    logic [21:0]    qe3;
    logic [34:0]    n3;
    logic [7:0]     q4;
    logic [10:0]    q5;
    logic [10:0]    q6;
  } st3_t;

  typedef struct packed {
    ddur_pkg::cat_t   cat;
    logic [22:0]      q1;
    logic [21:0]      q3;
    logic [10:0]      x;
    ddur_pkg::rbase_t rb;
    logic [9:0]       qb;
    logic [7:0]       v;
    logic [4:0]       w10;
  } st4_t;

  // configuration
  logic [1:0] us_r;
  logic       rnd_r;

  // pipeline
  logic v1_r, v2_r, v3_r, v4_r, vo_r;
  logic en1, en2, en3, en4, en_out;
  st1_t s1_r, s1_nxt;
  st2_t s2_r, s2_nxt;
  st3_t s3_r, s3_nxt;
  st4_t s4_r, s4_nxt;

  logic [ddur_pkg::WHOLE_W-1:0]  whole_r, whole_nxt;
  logic [ddur_pkg::TENTHS_W-1:0] tenths_r, tenths_nxt;
  logic                          has_r, has_nxt;
  logic [ddur_pkg::UNIT_W-1:0]   unit_r, unit_nxt;

  // stage 1 helpers
  logic [31:0] d;
  logic        feet_rules;
  logic        imperial;
  logic [32:0] sum1;
  logic [38:0] t125;
  logic [38:0] n3full;
  logic [24:0] d14;
  logic [20:0] d10;
  logic [18:0] d8;

  // stage 3 helpers
  logic [22:0] qe1;
  logic [29:0] rem1;
  logic [7:0]  qe2;
  logic [14:0] rem2;
  logic [56:0] prod3;
  logic [7:0]  qe4;
  logic [24:0] rem4;
  logic [10:0] qe5;
  logic [20:0] rem5;
  logic [10:0] qe6;
  logic [18:0] rem6;

  // stage 4 helpers
  logic [34:0] rem3;
  logic [10:0] xsel;
  logic [11:0] xh;
  logic [29:0] qbprod;
  logic [7:0]  vsel;
  logic [15:0] w10prod;

  // output helpers
  logic [15:0] rounded;
  logic [7:0]  tdig;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      us_r  <= ddur_pkg::US_METRIC;
      rnd_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        ddur_pkg::CFG_UNIT_SYSTEM:  us_r  <= cfg_data;
        ddur_pkg::CFG_ROUND_ENABLE: rnd_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  assign en_out      = !vo_r || out_ch.ready;
  assign en4         = !v4_r || en_out;
  assign en3         = !v3_r || en4;
  assign en2         = !v2_r || en3;
  assign en1         = !v1_r || en2;
  assign in_ch.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en1)    v1_r <= in_ch.valid;
      if (en2)    v2_r <= v1_r;
      if (en3)    v3_r <= v2_r;
      if (en4)    v4_r <= v3_r;
      if (en_out) vo_r <= v4_r;
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_comb begin
    d          = in_ch.distance_m;
    imperial   = us_r inside {ddur_pkg::US_YARDS, ddur_pkg::US_FEET};
    // altitude in yards mode follows the feet rules
    feet_rules = (us_r == ddur_pkg::US_FEET) ||
                 ((us_r == ddur_pkg::US_YARDS) && in_ch.is_altitude);

    if (!imperial) begin
      if (d > ddur_pkg::KM_WHOLE_ABOVE)       s1_nxt.cat = ddur_pkg::CAT_KM_WHOLE;
      else if (d > ddur_pkg::KM_TENTHS_ABOVE) s1_nxt.cat = ddur_pkg::CAT_KM_TENTHS;
      else                                    s1_nxt.cat = ddur_pkg::CAT_METERS;
    end else if (d >= ddur_pkg::MI_WHOLE_MIN) begin
      s1_nxt.cat = ddur_pkg::CAT_MI_WHOLE;
    end else if (feet_rules) begin
      s1_nxt.cat = (d >= ddur_pkg::MI_FT_MIN) ? ddur_pkg::CAT_MI_TENTHS : ddur_pkg::CAT_FEET;
    end else begin
      s1_nxt.cat = (d >= ddur_pkg::MI_YD_MIN) ? ddur_pkg::CAT_MI_TENTHS : ddur_pkg::CAT_YARDS;
    end

    s1_nxt.m  = d[9:0];
    sum1      = {1'b0, d} + 33'd500;
    s1_nxt.n1 = sum1[32:3];
    s1_nxt.n2 = {1'b0, d[13:0]} + 15'd50;

    // 125 = 128 - 2 - 1, 1250 = 1024 + 256 - 32 + 2
    t125      = ({7'd0, d} << 7) - ({7'd0, d} << 1) - {7'd0, d};
    n3full    = t125 + 39'd100584;
    s1_nxt.n3 = n3full[38:4];

    d14       = {11'd0, d[13:0]};
    s1_nxt.n4 = (d14 << 10) + (d14 << 8) - (d14 << 5) + (d14 << 1) + 25'd100584;
    d10       = {11'd0, d[9:0]};
    s1_nxt.n5 = (d10 << 10) + (d10 << 8) - (d10 << 5) + (d10 << 1);
    d8        = {11'd0, d[7:0]};
    s1_nxt.n6 = (d8 << 10) + (d8 << 8) - (d8 << 5) + (d8 << 1);
  end

  // ---------------------------------------------------------------- stage 2
  always_comb begin
    s2_nxt.cat = s1_r.cat;
    s2_nxt.m   = s1_r.m;
    s2_nxt.n1  = s1_r.n1;
    s2_nxt.n2  = s1_r.n2;
    s2_nxt.n3  = s1_r.n3;
    s2_nxt.n4  = s1_r.n4;
    s2_nxt.n5  = s1_r.n5;
    s2_nxt.n6  = s1_r.n6;
    s2_nxt.p1  = 54'(s1_r.n1) * 54'(ddur_pkg::R_KM);
    s2_nxt.p2  = 24'(s1_r.n2) * 24'(ddur_pkg::R_HM);
    // wide numerator: split into two partial products, summed next stage
    s2_nxt.p3h = 40'(s1_r.n3[34:17]) * 40'(ddur_pkg::R_MIW);
    s2_nxt.p3l = 39'(s1_r.n3[16:0]) * 39'(ddur_pkg::R_MIW);
    s2_nxt.p4  = 33'(s1_r.n4) * 33'(ddur_pkg::R_MIT);
    s2_nxt.p5  = 32'(s1_r.n5) * 32'(ddur_pkg::R_YD);
    s2_nxt.p6  = 30'(s1_r.n6) * 30'(ddur_pkg::R_FT);
  end

  // ---------------------------------------------------------------- stage 3
  always_comb begin
    // each estimate is the true quotient or one below it
    qe1  = s2_r.p1[52:30];
    rem1 = s2_r.n1 - (30'(qe1) * 30'd125);
    qe2  = s2_r.p2[22:15];
    rem2 = s2_r.n2 - (15'(qe2) * 15'd100);
    qe4  = s2_r.p4[32:25];
    rem4 = s2_r.n4 - (25'(qe4) * 25'd201168);
    qe5  = s2_r.p5[31:21];
    rem5 = s2_r.n5 - (21'(qe5) * 21'd1143);
    qe6  = s2_r.p6[29:19];
    rem6 = s2_r.n6 - (19'(qe6) * 19'd381);
    prod3 = {s2_r.p3h, 17'd0} + {18'd0, s2_r.p3l};

    s3_nxt.cat = s2_r.cat;
    s3_nxt.m   = s2_r.m;
    s3_nxt.q1  = qe1 + {22'd0, (rem1 >= 30'd125)};
    s3_nxt.q2  = qe2 + {7'd0, (rem2 >= 15'd100)};
    s3_nxt.qe3 = prod3[56:35];
    s3_nxt.n3  = s2_r.n3;
    s3_nxt.q4  = qe4 + {7'd0, (rem4 >= 25'd201168)};
    s3_nxt.q5  = qe5 + {10'd0, (rem5 >= 21'd1143)};
    s3_nxt.q6  = qe6 + {10'd0, (rem6 >= 19'd381)};
  end

  // ---------------------------------------------------------------- stage 4
  always_comb begin
    rem3 = s3_r.n3 - (35'(s3_r.qe3) * 35'd12573);

    case (s3_r.cat)
      ddur_pkg::CAT_METERS: xsel = {1'b0, s3_r.m};
      ddur_pkg::CAT_YARDS:  xsel = s3_r.q5;
      default:              xsel = s3_r.q6;
    endcase

    s4_nxt.rb = ddur_pkg::RB_NONE;
    if (rnd_r) begin
      case (s3_r.cat)
        ddur_pkg::CAT_METERS, ddur_pkg::CAT_YARDS: begin
          if (xsel < 11'd50)       s4_nxt.rb = ddur_pkg::RB_NONE;
          else if (xsel < 11'd200) s4_nxt.rb = ddur_pkg::RB_5;
          else                     s4_nxt.rb = ddur_pkg::RB_10;
        end
        ddur_pkg::CAT_FEET: begin
          if (xsel < 11'd100)      s4_nxt.rb = ddur_pkg::RB_NONE;
          else if (xsel < 11'd200) s4_nxt.rb = ddur_pkg::RB_5;
          else if (xsel < 11'd400) s4_nxt.rb = ddur_pkg::RB_10;
          else if (xsel < 11'd600) s4_nxt.rb = ddur_pkg::RB_25;
          else                     s4_nxt.rb = ddur_pkg::RB_50;
        end
        default: s4_nxt.rb = ddur_pkg::RB_NONE;
      endcase
    end

    xh     = {1'b0, xsel} + {7'd0, ddur_pkg::rb_half(s4_nxt.rb)};
    qbprod = 30'(xh) * 30'(ddur_pkg::rb_magic(s4_nxt.rb));

    // tenths source: hundreds of meters or tenths of a mile
    vsel    = (s3_r.cat == ddur_pkg::CAT_KM_TENTHS) ? s3_r.q2 : s3_r.q4;
    w10prod = 16'(vsel) * 16'd205;  // exact divide by ten below 1029

    s4_nxt.cat = s3_r.cat;
    s4_nxt.q1  = s3_r.q1;
    s4_nxt.q3  = s3_r.qe3 + {21'd0, (rem3 >= 35'd12573)};
    s4_nxt.x   = xsel;
    s4_nxt.qb  = qbprod[29:20];
    s4_nxt.v   = vsel;
    s4_nxt.w10 = w10prod[15:11];
  end

  // ---------------------------------------------------------------- output stage
  always_comb begin
    if (s4_r.rb == ddur_pkg::RB_NONE) rounded = {5'd0, s4_r.x};
    else rounded = 16'(s4_r.qb) * 16'(ddur_pkg::rb_base(s4_r.rb));
    tdig = s4_r.v - (8'(s4_r.w10) * 8'd10);

    whole_nxt  = {7'd0, rounded};
    tenths_nxt = '0;
    has_nxt    = 1'b0;
    unit_nxt   = ddur_pkg::UNIT_M;
    case (s4_r.cat)
      ddur_pkg::CAT_KM_WHOLE: begin
        whole_nxt = s4_r.q1;
        unit_nxt  = ddur_pkg::UNIT_KM;
      end
      ddur_pkg::CAT_KM_TENTHS: begin
        whole_nxt  = {18'd0, s4_r.w10};
        tenths_nxt = tdig[3:0];
        has_nxt    = 1'b1;
        unit_nxt   = ddur_pkg::UNIT_KM;
      end
      ddur_pkg::CAT_MI_WHOLE: begin
        whole_nxt = {1'b0, s4_r.q3};
        unit_nxt  = ddur_pkg::UNIT_MI;
      end
      ddur_pkg::CAT_MI_TENTHS: begin
        whole_nxt  = {18'd0, s4_r.w10};
        tenths_nxt = tdig[3:0];
        has_nxt    = 1'b1;
        unit_nxt   = ddur_pkg::UNIT_MI;
      end
      ddur_pkg::CAT_YARDS: unit_nxt = ddur_pkg::UNIT_YD;
      ddur_pkg::CAT_FEET:  unit_nxt = ddur_pkg::UNIT_FT;
      default:             unit_nxt = ddur_pkg::UNIT_M;
    endcase
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk) begin
    if (en1 && in_ch.valid) s1_r <= s1_nxt;
    if (en2 && v1_r)        s2_r <= s2_nxt;
    if (en3 && v2_r)        s3_r <= s3_nxt;
    if (en4 && v3_r)        s4_r <= s4_nxt;
    if (en_out && v4_r) begin
      whole_r  <= whole_nxt;
      tenths_r <= tenths_nxt;
      has_r    <= has_nxt;
      unit_r   <= unit_nxt;
    end
  end

  assign out_ch.valid        = vo_r;
  assign out_ch.whole_value  = whole_r;
  assign out_ch.tenths_digit = tenths_r;
  assign out_ch.has_tenths   = has_r;
  assign out_ch.unit_code    = unit_r;

endmodule
